// ===== hdl/step_detect_direction_reversal_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the step detector
// Each macro builds one labeled concurrent assertion with a synchronous
// active-low reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef STEP_DETECT_DIRECTION_REVERSAL_DEFINES_SVH
`define STEP_DETECT_DIRECTION_REVERSAL_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds in that cycle.
`define SDDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define SDDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sddr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step detector package
// Payload types for the sample request and the step result.
// ----------------------------------------------------------------------------
package sddr_pkg;

    localparam int AXIS_W   = 16;
    localparam int NUM_AXES = 3;
    localparam int COUNT_W  = 16;

    typedef logic signed [AXIS_W-1:0] t_axis;

    typedef struct packed {
        t_axis accel_x;
        t_axis accel_y;
        t_axis accel_z;
    } t_req;

    typedef struct packed {
        logic               step_seen;
        logic [COUNT_W-1:0] step_total;
    } t_res;

endpackage

// ===== hdl/step_detect_direction_reversal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step detector by reversal of the averaged acceleration direction
// Moving average over a window of samples per axis; a step is counted when
// the dot product of the new and the previous average is negative.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel (i_req_valid / o_req_ready / i_req) is one
// three-axis sample. Every request produces exactly one result on the output
// channel (o_res_valid / i_res_ready / o_res) carrying the step flag and the
// running 16-bit step total, which wraps.
// The block takes one request per cycle while o_req_ready is high. That rate
// is set by the running per-axis sum, which is updated with one add and one
// subtract per cycle in stage two.
// Stages: window memory read, sum update, reciprocal divide, products, and the
// dot product with the counter in the output register.
// Reset clears the window valid bits, the sums, the averages, the primed flag
// and the step counter at once; no clearing pass is needed, so requests are
// taken from the first cycle after reset.
// When the receiver stalls, the held result stays in the output register and
// requests keep entering until all five stages are full; then o_req_ready
// drops until the receiver takes the waiting result.
// ----------------------------------------------------------------------------
`include "step_detect_direction_reversal_defines.svh"

module step_detect_direction_reversal #(
    parameter int WINDOW = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  sddr_pkg::t_req i_req,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output sddr_pkg::t_res o_res
);

    // Window index width, running sum width and reciprocal constants.
    // The sum of WINDOW 16-bit samples needs 16 + clog2(WINDOW) signed bits.
    // Division by WINDOW uses m = ceil(2^(N+L) / WINDOW), which is exact for
    // all N-bit magnitudes when L = clog2(WINDOW).
    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int SUM_W   = sddr_pkg::AXIS_W + SLOT_W;
    localparam int MAG_W   = SUM_W;
    localparam int SHIFT   = MAG_W + SLOT_W;
    localparam int MULT_W  = MAG_W + 2;
    localparam int PROD_W  = MAG_W + MULT_W;
    localparam int PRODD_W = 2 * sddr_pkg::AXIS_W;
    localparam int DOT_W   = PRODD_W + 2;
    localparam longint unsigned MULT_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [MULT_W-1:0] RECIP = MULT_FULL[MULT_W-1:0];
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    // ------------------------------------------------------------------
    // Stage enables. A stage loads when it is empty or its contents move on.
    // ------------------------------------------------------------------
    logic s1_en, s2_en, s3_en, s4_en, s5_en;
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;

    assign s5_en = !r_s5_valid || i_res_ready;
    assign s4_en = !r_s4_valid || s5_en;
    assign s3_en = !r_s3_valid || s4_en;
    assign s2_en = !r_s2_valid || s3_en;
    assign s1_en = !r_s1_valid || s2_en;

    assign o_req_ready = s1_en;

    logic s1_load, s2_load, s3_load, s4_load, s5_load;
    assign s1_load = s1_en && i_req_valid;
    assign s2_load = s2_en && r_s1_valid;
    assign s3_load = s3_en && r_s2_valid;
    assign s4_load = s4_en && r_s3_valid;
    assign s5_load = s5_en && r_s4_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= i_req_valid;
            end
            if (s2_en) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_en) begin
                r_s3_valid <= r_s2_valid;
            end
            if (s4_en) begin
                r_s4_valid <= r_s3_valid;
            end
            if (s5_en) begin
                r_s5_valid <= r_s4_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window memory. The sample leaving the window is read at the
    // slot that the new sample overwrites in the same cycle. A slot that was
    // never written since reset counts as a zero sample.
    // ------------------------------------------------------------------
    sddr_pkg::t_req    r_window [WINDOW];
    logic [WINDOW-1:0] r_slot_vld;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    sddr_pkg::t_req    r_s1_sample;
    sddr_pkg::t_req    r_s1_old;
    logic              r_s1_old_vld;

    assign n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_old           <= r_window[r_slot];
            r_window[r_slot]   <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_slot_vld <= '0;
        end else if (s1_load) begin
            r_slot             <= n_slot;
            r_slot_vld[r_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_sample  <= i_req;
            r_s1_old_vld <= r_slot_vld[r_slot];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: running sums. While an item sits in this stage, r_sum holds
    // exactly that item's window sums.
    // ------------------------------------------------------------------
    sddr_pkg::t_axis        s1_new [sddr_pkg::NUM_AXES];
    sddr_pkg::t_axis        s1_old [sddr_pkg::NUM_AXES];
    logic signed [SUM_W-1:0] r_sum [sddr_pkg::NUM_AXES];
    logic signed [SUM_W-1:0] n_sum [sddr_pkg::NUM_AXES];

    assign s1_new[0] = r_s1_sample.accel_x;
    assign s1_new[1] = r_s1_sample.accel_y;
    assign s1_new[2] = r_s1_sample.accel_z;
    assign s1_old[0] = r_s1_old_vld ? r_s1_old.accel_x : '0;
    assign s1_old[1] = r_s1_old_vld ? r_s1_old.accel_y : '0;
    assign s1_old[2] = r_s1_old_vld ? r_s1_old.accel_z : '0;

    always_comb begin
        for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
            n_sum[a] = r_sum[a] + SUM_W'(s1_new[a]) - SUM_W'(s1_old[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else if (s2_load) begin
            for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
                r_sum[a] <= n_sum[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: window average, truncated toward zero. The magnitude is
    // divided by a reciprocal multiply and the sign is put back afterwards.
    // The previous average moves to r_prior as the new one arrives.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]           s2_mag  [sddr_pkg::NUM_AXES];
    logic [PROD_W-1:0]          s2_prod [sddr_pkg::NUM_AXES];
    logic [sddr_pkg::AXIS_W-1:0] s2_quo [sddr_pkg::NUM_AXES];
    sddr_pkg::t_axis            n_avg   [sddr_pkg::NUM_AXES];
    sddr_pkg::t_axis            r_avg   [sddr_pkg::NUM_AXES];
    sddr_pkg::t_axis            r_prior [sddr_pkg::NUM_AXES];
    logic                       r_primed;
    logic                       r_s3_primed;

    always_comb begin
        for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
            s2_mag[a]  = r_sum[a][SUM_W-1] ? (~r_sum[a] + MAG_W'(1)) : r_sum[a];
            s2_prod[a] = PROD_W'(s2_mag[a]) * PROD_W'(RECIP);
            s2_quo[a]  = s2_prod[a][SHIFT +: sddr_pkg::AXIS_W];
            n_avg[a]   = r_sum[a][SUM_W-1] ? (~s2_quo[a] + sddr_pkg::AXIS_W'(1))
                                           : s2_quo[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
                r_avg[a]   <= '0;
                r_prior[a] <= '0;
            end
        end else if (s3_load) begin
            r_primed <= 1'b1;
            for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
                r_avg[a]   <= n_avg[a];
                r_prior[a] <= r_avg[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_load) begin
            r_s3_primed <= r_primed;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: per-axis products of the previous and current averages.
    // ------------------------------------------------------------------
    logic signed [PRODD_W-1:0] r_prod [sddr_pkg::NUM_AXES];
    logic                      r_s4_primed;

    always_ff @(posedge i_clk) begin
        if (s4_load) begin
            r_s4_primed <= r_s3_primed;
            for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
                r_prod[a] <= r_prior[a] * r_avg[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: dot product sign, step counter and the output register.
    // A zero dot product is not a reversal.
    // ------------------------------------------------------------------
    logic signed [DOT_W-1:0]      s4_dot;
    logic                         s4_seen;
    logic [sddr_pkg::COUNT_W-1:0] r_count;
    logic [sddr_pkg::COUNT_W-1:0] n_count;
    sddr_pkg::t_res               r_res;

    assign s4_dot  = DOT_W'(r_prod[0]) + DOT_W'(r_prod[1]) + DOT_W'(r_prod[2]);
    assign s4_seen = r_s4_primed && s4_dot[DOT_W-1];
    assign n_count = r_count + sddr_pkg::COUNT_W'(s4_seen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (s5_load) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_load) begin
            r_res.step_seen  <= s4_seen;
            r_res.step_total <= n_count;
        end
    end

    assign o_res_valid = r_s5_valid;
    assign o_res       = r_res;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input back-pressure only ever comes from a stalled output.
    `SDDR_ASSERT_NOW(a_ready_low_only_when_full, i_clk, i_rst_n, !o_req_ready, o_res_valid && !i_res_ready, "input stalled while the output is free")
    // The step counter does not move while a result waits to be taken.
    `SDDR_ASSERT_NEXT(a_count_holds_on_stall, i_clk, i_rst_n, o_res_valid && !i_res_ready, r_count == $past(r_count), "step counter moved during an output stall")
    // The first item after reset never reports a step.
    `SDDR_ASSERT_NEXT(a_first_item_no_step, i_clk, i_rst_n, s5_load && !r_s4_primed, !o_res.step_seen, "step reported before a prior average existed")
    // Every accepted sample moves the window slot on.
    `SDDR_ASSERT_NEXT(a_slot_advances, i_clk, i_rst_n, i_req_valid && o_req_ready, r_slot != $past(r_slot), "window slot did not advance on an accepted sample")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the step detector by direction reversal
// Sends three-axis samples through the request channel and checks each step
// result against a cycle-free model of the averaging window, the dot product
// and the wrapping step counter. Covers directed corner cases, random traffic
// under several idle and stall mixes, a long receiver hold-off and a stretch
// of alternating motion that counts a step on most samples.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WINDOW      = 12;
    localparam int QUIET_LIMIT = 5000;   // cycles with no handshake at all
    localparam int DRAIN_WAIT  = 10;     // extra wait after the last result is returned
    localparam int HOLD_CYCLES = 300;
    localparam int STEP_AMP    = 24000;  // multiple of WINDOW, fits 16 bits

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic           req_valid = 1'b0;
    logic           req_ready;
    sddr_pkg::t_req req_data  = '0;
    logic           res_valid;
    logic           res_ready = 1'b0;
    sddr_pkg::t_res res_data;

    step_detect_direction_reversal #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(req_ready),
        .i_req      (req_data),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Model of the detector: the last WINDOW samples, their running sums,
    // the previous average and the step counter.
    longint     win_samples [WINDOW][sddr_pkg::NUM_AXES] = '{default: 0};
    int         win_pos        = 0;
    longint     run_sum [sddr_pkg::NUM_AXES] = '{default: 0};
    longint     last_avg[sddr_pkg::NUM_AXES] = '{default: 0};
    bit         have_avg       = 1'b0;
    logic [15:0] steps_counted = '0;

    sddr_pkg::t_res step_reports_due[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_request   = 0;
    int  hold_ticket    = 0;
    int  hold_taken     = 0;
    int  hold_left      = 0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;

    // State of the random walking-motion generator.
    int  swing_left = 0;
    bit  swing_neg  = 1'b0;
    int  swing_amp[sddr_pkg::NUM_AXES] = '{default: 0};

    function automatic sddr_pkg::t_res predict_step_report(sddr_pkg::t_req s);
        longint         smp[sddr_pkg::NUM_AXES];
        longint         avg[sddr_pkg::NUM_AXES];
        longint         dot;
        bit             seen;
        sddr_pkg::t_res r;
        smp[0] = $signed(s.accel_x);
        smp[1] = $signed(s.accel_y);
        smp[2] = $signed(s.accel_z);
        dot    = 0;
        seen   = 1'b0;
        for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
            run_sum[a] += smp[a] - win_samples[win_pos][a];
            win_samples[win_pos][a] = smp[a];
            // SystemVerilog integer division truncates toward zero.
            avg[a] = run_sum[a] / WINDOW;
        end
        win_pos = (win_pos == WINDOW - 1) ? 0 : win_pos + 1;
        if (have_avg) begin
            for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
                dot += last_avg[a] * avg[a];
            end
            // A zero dot product is not a reversal.
            seen = (dot < 0);
            if (seen) begin
                steps_counted = steps_counted + 16'd1;
            end
        end
        have_avg = 1'b1;
        for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
            last_avg[a] = avg[a];
        end
        r.step_seen  = seen;
        r.step_total = steps_counted;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Builds one sample from three axis values that fit in 16 bits.
    function automatic sddr_pkg::t_req pack_sample(input int x, input int y, input int z);
        sddr_pkg::t_req s;
        s.accel_x = 16'(x);
        s.accel_y = 16'(y);
        s.accel_z = 16'(z);
        return s;
    endfunction

    // Offers one request and returns once it has been taken. Valid is only
    // lowered when the sender decides to idle, so back-to-back requests keep
    // it high without a second assignment in the same step.
    task automatic send_sample(input sddr_pkg::t_req s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= s;
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        step_reports_due.push_back(predict_step_report(s));
    endtask

    // The sender stops until every outstanding result has been returned.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (step_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int corner16();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return -1;
            2: return 0;
            3: return 1;
            4: return 32767;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Mix of uniform noise, a walking-like swing along a random direction
    // with jitter, and per-axis corner values.
    function automatic sddr_pkg::t_req random_sample();
        sddr_pkg::t_req s;
        int             v[sddr_pkg::NUM_AXES];
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            s = sddr_pkg::t_req'(48'({$urandom, $urandom}));
            return s;
        end
        if (pick < 80) begin
            if (swing_left == 0) begin
                swing_left = $urandom_range(2, 14);
                swing_neg  = !swing_neg;
                if ($urandom_range(0, 3) == 0) begin
                    for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
                        swing_amp[a] = int'($urandom_range(0, 65535)) - 32768;
                    end
                end
            end
            swing_left--;
            for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
                v[a] = clamp16((swing_neg ? -swing_amp[a] : swing_amp[a])
                               + int'($urandom_range(0, 2000)) - 1000);
            end
        end else begin
            for (int a = 0; a < sddr_pkg::NUM_AXES; a++) begin
                v[a] = corner16();
            end
        end
        s = pack_sample(v[0], v[1], v[2]);
        return s;
    endfunction

    // Receiver: random stalls, or a long hold-off counted down here once a
    // test asks for one by moving the ticket on.
    always @(posedge i_clk) begin
        if (hold_ticket != hold_taken) begin
            hold_left  = hold_request;
            hold_taken = hold_ticket;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        sddr_pkg::t_res want;
        if (i_rst_n && res_valid && res_ready) begin
            if (step_reports_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result seen=%0b total=%0d",
                                          res_data.step_seen, res_data.step_total));
            end else begin
                want = step_reports_due.pop_front();
                if (res_data.step_seen !== want.step_seen) begin
                    report_mismatch($sformatf("step_seen got %b want %b",
                                              res_data.step_seen, want.step_seen));
                end
                if (res_data.step_total !== want.step_total) begin
                    report_mismatch($sformatf("step_total got %0d want %0d",
                                              res_data.step_total, want.step_total));
                end
            end
        end
    end

    // Watchdog: ends the run when no handshake happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && req_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // First item, zero dot product, partial window, extremes and wrap of the
    // window position.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_sample(pack_sample(1200, 0, 0));      // first average only, no step
        send_sample(pack_sample(0, 1200, 0));
        send_sample(pack_sample(-2400, 0, 0));     // dot product exactly zero
        send_sample(pack_sample(-2400, 0, 0));
        send_sample(pack_sample(32767, 0, 0));     // reversal
        send_sample(pack_sample(32767, 32767, 32767));
        send_sample(pack_sample(-32768, -32768, -32768));
        send_sample(pack_sample(-32768, -32768, -32768));
        send_sample(pack_sample(-1, 1, -1));
        send_sample(pack_sample(-13, 0, 0));
        send_sample(pack_sample(32767, -32768, 0));
        send_sample(pack_sample(0, 0, 0));         // window now full
        for (int i = 0; i < 4; i++) send_sample(pack_sample(32767, 32767, 32767));
        for (int i = 0; i < 4; i++) send_sample(pack_sample(-32768, -32768, -32768));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            send_sample(random_sample());
        end
        wait_drained();
    endtask

    // The receiver holds off while requests keep coming, so the pipeline
    // fills and the request channel stalls.
    task automatic test_receiver_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        hold_ticket    = hold_ticket + 1;
        for (int i = 0; i < 60; i++) begin
            send_sample(random_sample());
        end
        wait_drained();
    endtask

    // A pattern whose window sum is antiperiodic over twelve samples flips
    // the averaged direction on eleven of every twelve samples, so the step
    // total climbs on almost every request.
    task automatic test_alternating_steps();
        int k;
        int x;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int n = 0; n < 96; n++) begin
            k = n % 24;
            if (k == 0 || k == 12) begin
                x = 0;
            end else if (k < 12) begin
                x = (k % 2) ? -STEP_AMP : STEP_AMP;
            end else begin
                x = (k % 2) ? STEP_AMP : -STEP_AMP;
            end
            send_sample(pack_sample(x, 0, 0));
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(0, 0, 300);
        test_random_traffic(74, 0, 300);
        test_receiver_hold();
        test_random_traffic(0, 74, 300);
        test_random_traffic(12, 12, 300);
        test_alternating_steps();
        test_random_traffic(12, 12, 24);

        while (step_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
